/* hw/rtl/cwmv_pkg.sv */
`default_nettype none

package cwmv_pkg;

   // Dimensions and number formats
   localparam int MAX_DIM    = 4096;
   localparam int PIXEL_BITS = 8;
   localparam int FRAC_BITS  = 8;

   localparam int CFG_BITS   = 13;
   localparam int CSR_IDX_BITS = 3;
   localparam int DIM_BITS   = $clog2(MAX_DIM + 1);
   localparam int CNT_BITS   = $clog2(MAX_DIM);
   localparam int N_BITS     = 2 * DIM_BITS - 1;
   localparam int M_BITS     = 2 * N_BITS - 1;
   localparam int SUM_BITS   = 32;
   localparam int SQ_BITS    = 40;
   localparam int MUL_BITS   = 32;
   localparam int PROD_BITS  = 2 * MUL_BITS;
   localparam int NUM_BITS   = PROD_BITS + FRAC_BITS;
   localparam int DEN_BITS   = M_BITS;
   localparam int MEAN_BITS  = 16;
   localparam int VAR_BITS   = 22;
   localparam int Q_BITS     = VAR_BITS;
   localparam int STEP_BITS  = $clog2(Q_BITS);

   localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RESET  = CFG_BITS'(640);
   localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RESET = CFG_BITS'(480);
   localparam logic [CFG_BITS-1:0] WINDOW_COLS_RESET  = CFG_BITS'(64);
   localparam logic [CFG_BITS-1:0] WINDOW_ROWS_RESET  = CFG_BITS'(64);

   typedef logic [7:0]              pix_type;
   typedef logic [CFG_BITS-1:0]     cfg_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_index_type;
   typedef logic [DIM_BITS-1:0]     dim_type;
   typedef logic [MEAN_BITS-1:0]    mean_type;
   typedef logic [VAR_BITS-1:0]     var_type;

   localparam csr_index_type CSR_IMAGE_WIDTH  = CSR_IDX_BITS'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = CSR_IDX_BITS'(1);
   localparam csr_index_type CSR_WINDOW_COLS  = CSR_IDX_BITS'(2);
   localparam csr_index_type CSR_WINDOW_ROWS  = CSR_IDX_BITS'(3);

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_WIN,
      MUL_NN,
      MUL_NSQ_LO,
      MUL_NSQ_HI,
      MUL_SUM
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_CAP_N,
      ACC_CAP_M,
      ACC_LOAD,
      ACC_ADD_HI,
      ACC_SUB
   } acc_op_type;

   typedef enum logic [3:0] {
      ST_PIXEL,
      ST_WIN,
      ST_NCAP,
      ST_NN,
      ST_LO,
      ST_HI,
      ST_SQ,
      ST_DIFF,
      ST_VAR_GO,
      ST_VAR_RUN,
      ST_MEAN_GO,
      ST_MEAN_RUN,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic        pixel_take;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        div_start;
      logic        div_mean;
      logic        var_cap;
      logic        mean_cap;
      logic        res_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

   // Register value as used: zero acts as one, above MAX_DIM clamps.
   function automatic dim_type eff_dim(input cfg_type v);
      dim_type r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (CFG_BITS'(v) > CFG_BITS'(MAX_DIM)) begin
         r = DIM_BITS'(MAX_DIM);
      end else begin
         r = DIM_BITS'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/cwmv_req_if.sv */
`default_nettype none

interface cwmv_req_if;
   import cwmv_pkg::*;

   logic    valid;
   logic    ready;
   pix_type pixel;
   logic    frame_end;

   modport source(output valid, output pixel, output frame_end, input ready);
   modport sink(input valid, input pixel, input frame_end, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cwmv_rsp_if.sv */
`default_nettype none

interface cwmv_rsp_if;
   import cwmv_pkg::*;

   logic     valid;
   logic     ready;
   mean_type mean_value;
   var_type  variance_value;
   logic     window_too_big;

   modport source(output valid, output mean_value, output variance_value,
                  output window_too_big, input ready);
   modport sink(input valid, input mean_value, input variance_value,
                input window_too_big, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cwmv_csr_if.sv */
`default_nettype none

interface cwmv_csr_if;
   import cwmv_pkg::*;

   logic          valid;
   logic          ready;
   csr_index_type index;
   cfg_type       data;

   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/cwmv_div.sv */
`default_nettype none

module cwmv_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [cwmv_pkg::NUM_BITS-1:0] dividend,
   input  wire logic [cwmv_pkg::DEN_BITS-1:0] divisor,
   output logic                               done,
   output logic [cwmv_pkg::Q_BITS-1:0]        quotient
);
   import cwmv_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  sat_ff, sat_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [DEN_BITS-1:0]   rem_ff, rem_in;
   logic [DEN_BITS-1:0]   den_ff, den_in;
   logic [Q_BITS-1:0]     low_ff, low_in;

   logic [NUM_BITS-Q_BITS-1:0] high;
   logic [DEN_BITS:0]          trial;
   logic                       fits;

   assign high  = dividend[NUM_BITS-1:Q_BITS];
   assign trial = {rem_ff, low_ff[Q_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      sat_in  = sat_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         // quotient would not fit: saturate
         sat_in  = high >= (NUM_BITS - Q_BITS)'(divisor);
         step_in = STEP_BITS'(Q_BITS - 1);
         rem_in  = high[DEN_BITS-1:0];
         den_in  = divisor;
         low_in  = dividend[Q_BITS-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : trial[DEN_BITS-1:0];
         low_in = {low_ff[Q_BITS-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      sat_ff  <= sat_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      low_ff  <= low_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? '1 : low_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a run");

`default_nettype wire
endmodule

/* hw/rtl/cwmv_dp.sv */
`default_nettype none

module cwmv_dp (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cwmv_pkg::cmd_type       cmd,
   output cwmv_pkg::stat_type           stat,
   input  wire logic                    csr_write,
   input  wire cwmv_pkg::csr_index_type csr_index,
   input  wire cwmv_pkg::cfg_type       csr_data,
   input  wire cwmv_pkg::pix_type       pixel,
   output cwmv_pkg::mean_type           rsp_mean,
   output cwmv_pkg::var_type            rsp_var,
   output logic                         rsp_too_big
);
   import cwmv_pkg::*;

   cfg_type image_width_ff, image_width_in;
   cfg_type image_height_ff, image_height_in;
   cfg_type window_cols_ff, window_cols_in;
   cfg_type window_rows_ff, window_rows_in;

   logic [CNT_BITS-1:0] column_ff, column_in;
   logic [CNT_BITS-1:0] row_ff, row_in;
   logic                frame_over_ff, frame_over_in;
   logic [SUM_BITS-1:0] pixel_sum_ff, pixel_sum_in;
   logic [SQ_BITS-1:0]  square_sum_ff, square_sum_in;

   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [N_BITS-1:0]    n_ff, n_in;
   logic [M_BITS-1:0]    m_ff, m_in;
   mean_type             mean_ff, mean_in;
   var_type              var_ff, var_in;
   mean_type             rsp_mean_ff, rsp_mean_in;
   var_type              rsp_var_ff, rsp_var_in;
   logic                 rsp_too_big_ff, rsp_too_big_in;

   dim_type             w, h, wc, wr;
   logic                too_big;
   dim_type             c_lo, c_hi, r_lo, r_hi;
   dim_type             col_ext, row_ext;
   logic                in_win, col_last, row_last;
   logic [PIXEL_BITS-1:0]   pix;
   logic [2*PIXEL_BITS-1:0] pix_sq;
   logic [MUL_BITS-1:0]     mul_a, mul_b;
   logic [NUM_BITS-1:0]     div_num;
   logic [DEN_BITS-1:0]     div_den;
   logic                    div_done;
   logic [Q_BITS-1:0]       div_q;

   // Window bounds and raster position
   always_comb begin
      w       = eff_dim(image_width_ff);
      h       = eff_dim(image_height_ff);
      wc      = eff_dim(window_cols_ff);
      wr      = eff_dim(window_rows_ff);
      too_big = (wc > w) || (wr > h);
      c_lo    = (w - wc) >> 1;
      c_hi    = DIM_BITS'(({1'b0, w} + {1'b0, wc}) >> 1);
      r_lo    = (h - wr) >> 1;
      r_hi    = DIM_BITS'(({1'b0, h} + {1'b0, wr}) >> 1);
      col_ext = DIM_BITS'(column_ff);
      row_ext = DIM_BITS'(row_ff);
      in_win  = !too_big && (col_ext >= c_lo) && (col_ext < c_hi) &&
                (row_ext >= r_lo) && (row_ext < r_hi);
      col_last = (col_ext + 1'b1) >= w;
      row_last = (row_ext + 1'b1) >= h;
      pix      = pixel[PIXEL_BITS-1:0];
      pix_sq   = (2*PIXEL_BITS)'(pix) * (2*PIXEL_BITS)'(pix);
   end

   always_comb begin
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      window_cols_in  = window_cols_ff;
      window_rows_in  = window_rows_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data;
            CSR_IMAGE_HEIGHT: image_height_in = csr_data;
            CSR_WINDOW_COLS:  window_cols_in  = csr_data;
            CSR_WINDOW_ROWS:  window_rows_in  = csr_data;
            default: ;
         endcase
      end
   end

   // Per-item accumulation; clear once the result is handed over
   always_comb begin
      column_in     = column_ff;
      row_in        = row_ff;
      frame_over_in = frame_over_ff;
      pixel_sum_in  = pixel_sum_ff;
      square_sum_in = square_sum_ff;
      if (cmd.res_load) begin
         column_in     = '0;
         row_in        = '0;
         frame_over_in = 1'b0;
         pixel_sum_in  = '0;
         square_sum_in = '0;
      end else if (cmd.pixel_take && !frame_over_ff) begin
         if (in_win) begin
            pixel_sum_in  = pixel_sum_ff + SUM_BITS'(pix);
            square_sum_in = square_sum_ff + SQ_BITS'(pix_sq);
         end
         if (col_last) begin
            column_in = '0;
            if (row_last) begin
               frame_over_in = 1'b1;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   // Shared multiplier, product registered
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_WIN: begin
            mul_a = MUL_BITS'(wc);
            mul_b = MUL_BITS'(wr);
         end
         MUL_NN: begin
            mul_a = MUL_BITS'(n_ff);
            mul_b = MUL_BITS'(n_ff);
         end
         MUL_NSQ_LO: begin
            mul_a = MUL_BITS'(n_ff);
            mul_b = square_sum_ff[MUL_BITS-1:0];
         end
         MUL_NSQ_HI: begin
            mul_a = MUL_BITS'(n_ff);
            mul_b = MUL_BITS'(square_sum_ff[SQ_BITS-1:MUL_BITS]);
         end
         MUL_SUM: begin
            mul_a = pixel_sum_ff;
            mul_b = pixel_sum_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
   end

   // N, N^2 and N*sumsq - sum^2, all modulo 2^64
   always_comb begin
      n_in   = n_ff;
      m_in   = m_ff;
      acc_in = acc_ff;
      unique case (cmd.acc_op)
         ACC_CAP_N:  n_in   = prod_ff[N_BITS-1:0];
         ACC_CAP_M:  m_in   = prod_ff[M_BITS-1:0];
         ACC_LOAD:   acc_in = prod_ff;
         ACC_ADD_HI: acc_in = acc_ff + {prod_ff[PROD_BITS-MUL_BITS-1:0], {MUL_BITS{1'b0}}};
         ACC_SUB:    acc_in = acc_ff - prod_ff;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.div_mean) begin
         div_num = NUM_BITS'({pixel_sum_ff, {FRAC_BITS{1'b0}}});
         div_den = DEN_BITS'(n_ff);
      end else begin
         div_num = {acc_ff, {FRAC_BITS{1'b0}}};
         div_den = m_ff;
      end
   end

   cwmv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   assign stat.div_done = div_done;

   always_comb begin
      mean_in        = mean_ff;
      var_in         = var_ff;
      rsp_mean_in    = rsp_mean_ff;
      rsp_var_in     = rsp_var_ff;
      rsp_too_big_in = rsp_too_big_ff;
      if (cmd.var_cap) begin
         var_in = div_q;
      end
      if (cmd.mean_cap) begin
         mean_in = (div_q[Q_BITS-1:MEAN_BITS] != '0) ? '1 : div_q[MEAN_BITS-1:0];
      end
      if (cmd.res_load) begin
         rsp_too_big_in = too_big;
         rsp_mean_in    = too_big ? '0 : mean_ff;
         rsp_var_in     = too_big ? '0 : var_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         window_cols_ff  <= WINDOW_COLS_RESET;
         window_rows_ff  <= WINDOW_ROWS_RESET;
         column_ff       <= '0;
         row_ff          <= '0;
         frame_over_ff   <= 1'b0;
         pixel_sum_ff    <= '0;
         square_sum_ff   <= '0;
      end else begin
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         window_cols_ff  <= window_cols_in;
         window_rows_ff  <= window_rows_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         frame_over_ff   <= frame_over_in;
         pixel_sum_ff    <= pixel_sum_in;
         square_sum_ff   <= square_sum_in;
      end
      prod_ff        <= prod_in;
      acc_ff         <= acc_in;
      n_ff           <= n_in;
      m_ff           <= m_in;
      mean_ff        <= mean_in;
      var_ff         <= var_in;
      rsp_mean_ff    <= rsp_mean_in;
      rsp_var_ff     <= rsp_var_in;
      rsp_too_big_ff <= rsp_too_big_in;
   end

   assign rsp_mean    = rsp_mean_ff;
   assign rsp_var     = rsp_var_ff;
   assign rsp_too_big = rsp_too_big_ff;

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> (pixel_sum_ff == '0 && square_sum_ff == '0 && column_ff == '0))
      else $error("frame state not cleared after result");

`default_nettype wire
endmodule

/* hw/rtl/cwmv_ctrl.sv */
`default_nettype none

module cwmv_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_frame_end,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire cwmv_pkg::stat_type stat,
   output cwmv_pkg::cmd_type       cmd
);
   import cwmv_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_PIXEL: begin
            if (req_valid && req_frame_end) begin
               state_in = ST_WIN;
            end
         end
         ST_WIN:      state_in = ST_NCAP;
         ST_NCAP:     state_in = ST_NN;
         ST_NN:       state_in = ST_LO;
         ST_LO:       state_in = ST_HI;
         ST_HI:       state_in = ST_SQ;
         ST_SQ:       state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_VAR_GO;
         ST_VAR_GO:   state_in = ST_VAR_RUN;
         ST_VAR_RUN: begin
            if (stat.div_done) begin
               state_in = ST_MEAN_GO;
            end
         end
         ST_MEAN_GO:  state_in = ST_MEAN_RUN;
         ST_MEAN_RUN: begin
            if (stat.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (rsp_free) begin
               state_in = ST_PIXEL;
            end
         end
         default:     state_in = ST_PIXEL;
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      cmd.pixel_take = 1'b0;
      cmd.mul_sel    = MUL_NONE;
      cmd.acc_op     = ACC_NONE;
      cmd.div_start  = 1'b0;
      cmd.div_mean   = 1'b0;
      cmd.var_cap    = 1'b0;
      cmd.mean_cap   = 1'b0;
      cmd.res_load   = 1'b0;
      unique case (state_ff)
         ST_PIXEL: begin
            req_ready      = 1'b1;
            cmd.pixel_take = req_valid;
         end
         ST_WIN:  cmd.mul_sel = MUL_WIN;
         ST_NCAP: cmd.acc_op  = ACC_CAP_N;
         ST_NN:   cmd.mul_sel = MUL_NN;
         ST_LO: begin
            cmd.acc_op  = ACC_CAP_M;
            cmd.mul_sel = MUL_NSQ_LO;
         end
         ST_HI: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_sel = MUL_NSQ_HI;
         end
         ST_SQ: begin
            cmd.acc_op  = ACC_ADD_HI;
            cmd.mul_sel = MUL_SUM;
         end
         ST_DIFF:     cmd.acc_op = ACC_SUB;
         ST_VAR_GO:   cmd.div_start = 1'b1;
         ST_VAR_RUN:  cmd.var_cap = stat.div_done;
         ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_mean  = 1'b1;
         end
         ST_MEAN_RUN: cmd.mean_cap = stat.div_done;
         ST_LOAD:     cmd.res_load = rsp_free;
         default: ;
      endcase
   end

   // hold the result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_PIXEL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before it was taken");

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> (state_ff == ST_VAR_RUN || state_ff == ST_MEAN_RUN))
      else $error("division finished outside a wait state");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |=> rsp_valid_ff)
      else $error("result load did not raise valid");

`default_nettype wire
endmodule

/* hw/rtl/centered_window_mean_variance.sv */
// Centred-window mean and population variance of a gray frame.
//
// req_chan takes one 8-bit pixel per item in raster order; frame_end marks
// the frame's last pixel. Row and column are tracked internally. Pixels
// inside the window centred in the image add to a sum and a sum of squares.
// After the frame_end item, one item appears on rsp_chan: the mean and the
// population variance, each with 8 fractional bits, and window_too_big.
// csr_chan writes image_width (0), image_height (1), window_cols (2) and
// window_rows (3); it is always ready and should be used between frames.
//
// Throughput: one pixel per cycle within a frame. After the frame_end item
// the block computes (products on one shared 32x32 multiplier, then two
// 22-step runs of a one-bit-per-cycle divider), and req_chan stays not
// ready until the result is loaded and rsp_chan.valid rises.
// A result waits in the output register while the next frame streams in;
// a second result is held back, with req_chan not ready, until the first
// has been taken.
// Reset restores the default registers (640x480 image, 64x64 window) and
// clears the frame counters and sums.
`default_nettype none

module centered_window_mean_variance (
   input wire logic   clock,
   input wire logic   reset,
   cwmv_req_if.sink   req_chan,
   cwmv_rsp_if.source rsp_chan,
   cwmv_csr_if.sink   csr_chan
);
   import cwmv_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     csr_write;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   cwmv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_frame_end (req_chan.frame_end),
      .req_ready     (req_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   cwmv_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .csr_write   (csr_write),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .pixel       (req_chan.pixel),
      .rsp_mean    (rsp_chan.mean_value),
      .rsp_var     (rsp_chan.variance_value),
      .rsp_too_big (rsp_chan.window_too_big)
   );

endmodule

`default_nettype wire

/* tb/sv/tb_centered_window_mean_variance.sv */
module tb_centered_window_mean_variance;
   import cwmv_pkg::*;

   localparam int PERIOD         = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int IDLE_PERCENT   = 36;
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PIXELS  = 400;
   localparam int RANDOM_FRAMES  = 40;
   localparam int STEADY_FROM    = 150;
   localparam int STEADY_TO      = 250;
   localparam int LONG_FRAME     = 64;
   localparam longint unsigned MEAN_CEIL = (64'd1 << MEAN_BITS) - 1;
   localparam longint unsigned VAR_CEIL  = (64'd1 << VAR_BITS) - 1;

   typedef struct packed {
      mean_type mean;
      var_type  variance;
      logic     too_big;
   } window_stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cwmv_req_if pixel_in ();
   cwmv_rsp_if stats_out ();
   cwmv_csr_if reg_bus ();

   centered_window_mean_variance dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (pixel_in),
      .rsp_chan (stats_out),
      .csr_chan (reg_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Shadow of the block: register file, frame position and window sums
   cfg_type          geometry [4];
   int unsigned      col_pos        = 0;
   int unsigned      row_pos        = 0;
   longint unsigned  pix_total      = 0;
   longint unsigned  sq_total       = 0;
   bit               rows_exhausted = 1'b0;
   window_stats_type pending_stats [$];

   int unsigned mismatches   = 0;
   int unsigned quiet_cycles = 0;
   bit          steady       = 1'b0;

   function automatic longint unsigned span_of(input cfg_type v);
      if (v == '0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return v;
   endfunction

   function automatic void log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endfunction

   // Advance the frame by one pixel; on frame_end queue the window statistics.
   function automatic void accumulate_pixel(input pix_type p, input logic last);
      longint unsigned  w, h, wc, wr, n, m, d, q, r, pv, mean_fx, var_fx;
      bit               too_big;
      window_stats_type s;
      w  = span_of(geometry[CSR_IMAGE_WIDTH]);
      h  = span_of(geometry[CSR_IMAGE_HEIGHT]);
      wc = span_of(geometry[CSR_WINDOW_COLS]);
      wr = span_of(geometry[CSR_WINDOW_ROWS]);
      pv = p;
      too_big = (wc > w) || (wr > h);
      if (!rows_exhausted) begin
         if (!too_big && col_pos >= (w - wc) / 2 && col_pos < (w + wc) / 2 &&
             row_pos >= (h - wr) / 2 && row_pos < (h + wr) / 2) begin
            pix_total += pv;
            sq_total  += pv * pv;
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            if (row_pos + 1 >= h) rows_exhausted = 1'b1;
            else row_pos++;
         end else begin
            col_pos++;
         end
      end
      if (last) begin
         mean_fx = 0;
         var_fx  = 0;
         if (!too_big) begin
            n = wc * wr;
            m = n * n;
            d = n * sq_total - pix_total * pix_total;
            q = d / m;
            r = d % m;
            mean_fx = (pix_total << FRAC_BITS) / n;
            if (q > (VAR_CEIL >> FRAC_BITS)) var_fx = VAR_CEIL;
            else var_fx = (q << FRAC_BITS) + (r << FRAC_BITS) / m;
            if (mean_fx > MEAN_CEIL) mean_fx = MEAN_CEIL;
            if (var_fx > VAR_CEIL) var_fx = VAR_CEIL;
         end
         s.mean     = mean_type'(mean_fx);
         s.variance = var_type'(var_fx);
         s.too_big  = too_big;
         pending_stats.push_back(s);
         col_pos        = 0;
         row_pos        = 0;
         pix_total      = 0;
         sq_total       = 0;
         rows_exhausted = 1'b0;
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so a following item keeps the channel busy.
   task automatic send_pixel(input pix_type p, input logic last);
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         pixel_in.valid <= 1'b0;
         @(negedge clock);
      end
      pixel_in.valid     <= 1'b1;
      pixel_in.pixel     <= p;
      pixel_in.frame_end <= last;
      @(posedge clock);
      while (!pixel_in.ready) @(posedge clock);
      accumulate_pixel(p, last);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input cfg_type val);
      reg_bus.valid <= 1'b1;
      reg_bus.index <= idx;
      reg_bus.data  <= val;
      @(posedge clock);
      while (!reg_bus.ready) @(posedge clock);
      if (idx <= CSR_WINDOW_ROWS) geometry[idx] = val;
      @(negedge clock);
      reg_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, wait for every outstanding result, then let the divider drain.
   task automatic settle();
      pixel_in.valid <= 1'b0;
      while (pending_stats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_reset_defaults();
      // default window starts far below row 0, so nothing counts
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b1);
   endtask

   task automatic test_widest_spread();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd2);
      write_reg(CSR_IMAGE_HEIGHT, 13'd1);
      write_reg(CSR_WINDOW_COLS, 13'd2);
      write_reg(CSR_WINDOW_ROWS, 13'd1);
      send_pixel(8'h00, 1'b0);
      send_pixel(8'hFF, 1'b1);
   endtask

   task automatic test_zero_registers();
      settle();
      write_reg(CSR_IMAGE_WIDTH, '0);
      write_reg(CSR_IMAGE_HEIGHT, '0);
      write_reg(CSR_WINDOW_COLS, '0);
      write_reg(CSR_WINDOW_ROWS, '0);
      send_pixel(8'hFF, 1'b1);
   endtask

   task automatic test_window_too_big();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd3);
      write_reg(CSR_IMAGE_HEIGHT, 13'd1);
      write_reg(CSR_WINDOW_COLS, 13'd4);
      write_reg(CSR_WINDOW_ROWS, 13'd1);
      send_pixel(8'd200, 1'b0);
      send_pixel(8'd17, 1'b1);
   endtask

   task automatic test_extra_pixels();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd2);
      write_reg(CSR_IMAGE_HEIGHT, 13'd2);
      write_reg(CSR_WINDOW_COLS, 13'd1);
      write_reg(CSR_WINDOW_ROWS, 13'd1);
      send_pixel(8'd90, 1'b0);
      send_pixel(8'd3, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd128, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd77, 1'b1);
   endtask

   task automatic test_clamped_early_end();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'h1FFF);
      write_reg(CSR_IMAGE_HEIGHT, 13'd4097);
      write_reg(CSR_WINDOW_COLS, 13'd4096);
      write_reg(CSR_WINDOW_ROWS, 13'd4096);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'hFF, 1'b1);
   endtask

   task automatic test_mid_frame_write();
      settle();
      write_reg(CSR_IMAGE_WIDTH, 13'd4);
      write_reg(CSR_IMAGE_HEIGHT, 13'd2);
      write_reg(CSR_WINDOW_COLS, 13'd2);
      write_reg(CSR_WINDOW_ROWS, 13'd2);
      send_pixel(8'd10, 1'b0);
      send_pixel(8'd240, 1'b0);
      send_pixel(8'd33, 1'b0);
      settle();
      // indexes past the register file must leave the geometry alone
      for (int k = CSR_WINDOW_ROWS + 1; k < 2 ** CSR_IDX_BITS; k++)
         write_reg(csr_index_type'(k), cfg_type'($urandom));
      write_reg(CSR_WINDOW_COLS, 13'd4);
      send_pixel(8'd199, 1'b0);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd254, 1'b1);
   endtask

   task automatic test_random_frames();
      int              sent;
      int              frames;
      int              npix;
      int              pick;
      bit              calm;
      longint unsigned total;
      cfg_type         v;
      pix_type         p;
      sent   = 0;
      frames = 0;
      while (sent < RANDOM_PIXELS || frames < RANDOM_FRAMES) begin
         calm = (sent >= STEADY_FROM && sent < STEADY_TO);
         // keep the geometry during the calm stretch so nothing pauses
         if (frames == 0 || (!calm && $urandom_range(0, 3) == 0)) begin
            settle();
            for (int k = CSR_IMAGE_WIDTH; k <= CSR_WINDOW_ROWS; k++) begin
               if ($urandom_range(0, 3) != 0) begin
                  case ($urandom_range(0, 19))
                     0:       v = '0;
                     1:       v = cfg_type'($urandom_range(MAX_DIM, 2 ** CFG_BITS - 1));
                     2:       v = cfg_type'($urandom_range(9, 40));
                     default: v = cfg_type'($urandom_range(1, 8));
                  endcase
                  write_reg(csr_index_type'(k), v);
               end
            end
         end
         steady <= calm;
         total = span_of(geometry[CSR_IMAGE_WIDTH]) * span_of(geometry[CSR_IMAGE_HEIGHT]);
         pick  = $urandom_range(0, 99);
         // huge frames end early; otherwise mostly whole frames, some short, some long
         if (total > LONG_FRAME) npix = $urandom_range(1, 24);
         else if (pick < 70) npix = int'(total);
         else if (pick < 85 && total > 1) npix = $urandom_range(1, int'(total) - 1);
         else npix = int'(total) + $urandom_range(1, 4);
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else p = pix_type'($urandom);
            send_pixel(p, i == npix - 1);
         end
         sent += (npix > int'(total)) ? int'(total) : npix;
         frames++;
      end
      steady <= 1'b0;
   endtask

   initial begin
      stats_out.ready = 1'b0;
      forever begin
         @(negedge clock);
         stats_out.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      window_stats_type want;
      if (!reset && stats_out.valid && stats_out.ready) begin
         if (pending_stats.size() == 0) begin
            log_mismatch($sformatf("result with none expected: mean=%0d var=%0d big=%0d",
                                   stats_out.mean_value, stats_out.variance_value,
                                   stats_out.window_too_big));
         end else begin
            want = pending_stats.pop_front();
            if (stats_out.mean_value !== want.mean)
               log_mismatch($sformatf("mean_value expected %0d got %0d",
                                      want.mean, stats_out.mean_value));
            if (stats_out.variance_value !== want.variance)
               log_mismatch($sformatf("variance_value expected %0d got %0d",
                                      want.variance, stats_out.variance_value));
            if (stats_out.window_too_big !== want.too_big)
               log_mismatch($sformatf("window_too_big expected %0d got %0d",
                                      want.too_big, stats_out.window_too_big));
         end
      end
   end

   always @(posedge clock) begin
      if ((pixel_in.valid && pixel_in.ready) || (stats_out.valid && stats_out.ready) ||
          (reg_bus.valid && reg_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      pixel_in.valid     = 1'b0;
      pixel_in.pixel     = '0;
      pixel_in.frame_end = 1'b0;
      reg_bus.valid      = 1'b0;
      reg_bus.index      = '0;
      reg_bus.data       = '0;
      geometry[CSR_IMAGE_WIDTH]  = IMAGE_WIDTH_RESET;
      geometry[CSR_IMAGE_HEIGHT] = IMAGE_HEIGHT_RESET;
      geometry[CSR_WINDOW_COLS]  = WINDOW_COLS_RESET;
      geometry[CSR_WINDOW_ROWS]  = WINDOW_ROWS_RESET;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_widest_spread();
      test_zero_registers();
      test_window_too_big();
      test_extra_pixels();
      test_clamped_early_end();
      test_mid_frame_write();
      test_random_frames();

      settle();
      if (mismatches == 0 && pending_stats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
